// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication failed");

`endif

// File: rtl/ets_pkg.sv
// Types, constants and table functions of the engine test sequencer.
package ets_pkg;

   // Field and register widths
   localparam int REG_BITS       = 14;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CODE_BITS      = 5;
   localparam int NUM_STATES     = 17;
   localparam int NUM_CHECKS     = 3;
   localparam int P_BITS         = 20;
   localparam int TIMER_BITS_DEF = 14;

   // State codes referenced by name
   localparam logic [CODE_BITS-1:0] CODE_SHUTDOWN1 = 5'd13;
   localparam logic [CODE_BITS-1:0] CODE_MAX       = 5'd16;

   // Actions
   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_REQUEST = 3'd1;
   localparam logic [2:0] ACT_ABORT   = 3'd2;
   localparam logic [2:0] ACT_SAFE    = 3'd3;
   localparam logic [2:0] ACT_SAMPLE  = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_COUNTDOWN  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PURGE_DUR  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PURGE_DLY  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IGNITION   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IGNITION2  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIRE_DUR   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRADIENT   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AUTO_ABORT = 3'd7;

   // Register reset values
   localparam logic [REG_BITS-1:0] RST_COUNTDOWN = 14'd9850;
   localparam logic [REG_BITS-1:0] RST_PURGE_DUR = 14'd0;
   localparam logic [REG_BITS-1:0] RST_PURGE_DLY = 14'd0;
   localparam logic [REG_BITS-1:0] RST_IGNITION  = 14'd150;
   localparam logic [REG_BITS-1:0] RST_IGNITION2 = 14'd0;
   localparam logic [REG_BITS-1:0] RST_FIRE_DUR  = 14'd5850;
   localparam logic [REG_BITS-1:0] RST_GRADIENT  = 14'd200;
   localparam logic                RST_AUTO      = 1'b1;

   // Pressure margins in 1/16 psi: 15 psi and 10 psi
   localparam logic signed [P_BITS:0] MARGIN_15PSI = 21'sd240;
   localparam logic signed [P_BITS:0] MARGIN_10PSI = 21'sd160;

   typedef enum logic [NUM_STATES-1:0] {
      ST_FULLY_CLOSED     = 17'b0_0000_0000_0000_0001,
      ST_GN2_IN           = 17'b0_0000_0000_0000_0010,
      ST_HOLD_PRESSURE    = 17'b0_0000_0000_0000_0100,
      ST_DRY_RUN          = 17'b0_0000_0000_0000_1000,
      ST_FILLING          = 17'b0_0000_0000_0001_0000,
      ST_PRE_PRESS        = 17'b0_0000_0000_0010_0000,
      ST_PRESS            = 17'b0_0000_0000_0100_0000,
      ST_TERMINAL_COUNT   = 17'b0_0000_0000_1000_0000,
      ST_PURGE            = 17'b0_0000_0001_0000_0000,
      ST_PURGE_SHUTDOWN   = 17'b0_0000_0010_0000_0000,
      ST_MAIN_VALVES_OPEN = 17'b0_0000_0100_0000_0000,
      ST_FIRE1            = 17'b0_0000_1000_0000_0000,
      ST_FIRE2            = 17'b0_0001_0000_0000_0000,
      ST_SHUTDOWN1        = 17'b0_0010_0000_0000_0000,
      ST_SHUTDOWN2        = 17'b0_0100_0000_0000_0000,
      ST_EXCESS1          = 17'b0_1000_0000_0000_0000,
      ST_EXCESS2          = 17'b1_0000_0000_0000_0000
   } seq_state_type;

   typedef struct packed {
      logic [REG_BITS-1:0] countdown_delay_ms;
      logic [REG_BITS-1:0] purge_duration_ms;
      logic [REG_BITS-1:0] purge_delay_ms;
      logic [REG_BITS-1:0] ignition_delay_ms;
      logic [REG_BITS-1:0] ignition2_delay_ms;
      logic [REG_BITS-1:0] fire_duration_ms;
      logic [REG_BITS-1:0] gradient_abort_ms;
      logic                auto_abort_on;
   } csr_type;

   typedef struct packed {
      logic [2:0]           action;
      logic [CODE_BITS-1:0] requested_state;
      logic                 safe_flag;
      logic [P_BITS-1:0]    p_ox_tank;
      logic [P_BITS-1:0]    p_fuel_tank;
      logic [P_BITS-1:0]    p_ox_inlet;
      logic [P_BITS-1:0]    p_fuel_inlet;
      logic [P_BITS-1:0]    p_upper_line;
   } item_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]  current_state;
      logic [NUM_STATES-1:0] allowed_mask;
      logic                  mask_changed;
      logic                  state_changed;
      logic                  gradient_trip;
      logic                  bad_request;
   } result_type;

   // Map a code 0..16 to its one-hot state
   function automatic seq_state_type code_to_state(input logic [CODE_BITS-1:0] code);
      return seq_state_type'(NUM_STATES'(1) << code);
   endfunction

   // Encode a one-hot state into its code
   function automatic logic [CODE_BITS-1:0] state_to_code(input seq_state_type st);
      logic [CODE_BITS-1:0] code;
      code = '0;
      for (int i = 0; i < NUM_STATES; i++) begin
         if (st[i]) code = code | CODE_BITS'(i);
      end
      return code;
   endfunction

   function automatic logic in_fire_zone(input seq_state_type st);
      return (st == ST_MAIN_VALVES_OPEN) || (st == ST_FIRE1) || (st == ST_FIRE2);
   endfunction

   // Allowed-next mask: always part plus the part gated by the safe flag
   function automatic logic [NUM_STATES-1:0] allowed_mask(input seq_state_type st,
                                                         input logic safe);
      logic [NUM_STATES-1:0] always_m;
      logic [NUM_STATES-1:0] safe_m;
      always_m = '0;
      safe_m   = '0;
      case (st)
         ST_FULLY_CLOSED: begin
            always_m = 17'h04030; safe_m = 17'h00002;
         end
         ST_GN2_IN: begin
            always_m = 17'h00001; safe_m = 17'h04004;
         end
         ST_HOLD_PRESSURE:    safe_m   = 17'h0400A;
         ST_DRY_RUN:          always_m = 17'h00010;
         ST_FILLING:          always_m = 17'h04021;
         ST_PRE_PRESS: begin
            always_m = 17'h04011; safe_m = 17'h00040;
         end
         ST_PRESS:            safe_m   = 17'h040A0;
         ST_TERMINAL_COUNT:   safe_m   = 17'h04140;
         ST_PURGE:            safe_m   = 17'h04200;
         ST_PURGE_SHUTDOWN:   safe_m   = 17'h04400;
         ST_MAIN_VALVES_OPEN: begin
            always_m = 17'h02000; safe_m = 17'h00800;
         end
         ST_FIRE1: begin
            always_m = 17'h02000; safe_m = 17'h01000;
         end
         ST_FIRE2:            always_m = 17'h02000;
         ST_SHUTDOWN1:        safe_m   = 17'h04000;
         ST_SHUTDOWN2:        safe_m   = 17'h08001;
         ST_EXCESS1:          safe_m   = 17'h10000;
         ST_EXCESS2:          always_m = 17'h00001;
         default: begin
            always_m = '0; safe_m = '0;
         end
      endcase
      return always_m | (safe ? safe_m : '0);
   endfunction

   // Timed states carry a dwell register and a successor
   function automatic logic state_is_timed(input seq_state_type st);
      return (st == ST_TERMINAL_COUNT) || (st == ST_PURGE) || (st == ST_PURGE_SHUTDOWN) ||
             (st == ST_MAIN_VALVES_OPEN) || (st == ST_FIRE1) || (st == ST_FIRE2) ||
             (st == ST_SHUTDOWN1);
   endfunction

   function automatic logic [CSR_INDEX_BITS-1:0] dwell_reg_index(input seq_state_type st);
      logic [CSR_INDEX_BITS-1:0] idx;
      case (st)
         ST_TERMINAL_COUNT:   idx = REG_COUNTDOWN;
         ST_PURGE:            idx = REG_PURGE_DUR;
         ST_PURGE_SHUTDOWN:   idx = REG_PURGE_DLY;
         ST_MAIN_VALVES_OPEN: idx = REG_IGNITION;
         ST_FIRE1:            idx = REG_IGNITION2;
         ST_FIRE2:            idx = REG_FIRE_DUR;
         ST_SHUTDOWN1:        idx = REG_PURGE_DUR;
         default:             idx = REG_AUTO_ABORT;
      endcase
      return idx;
   endfunction

   function automatic seq_state_type dwell_next(input seq_state_type st);
      seq_state_type nxt;
      case (st)
         ST_TERMINAL_COUNT:   nxt = ST_PURGE;
         ST_PURGE:            nxt = ST_PURGE_SHUTDOWN;
         ST_PURGE_SHUTDOWN:   nxt = ST_MAIN_VALVES_OPEN;
         ST_MAIN_VALVES_OPEN: nxt = ST_FIRE1;
         ST_FIRE1:            nxt = ST_FIRE2;
         ST_FIRE2:            nxt = ST_SHUTDOWN1;
         ST_SHUTDOWN1:        nxt = ST_SHUTDOWN2;
         default:             nxt = ST_FULLY_CLOSED;
      endcase
      return nxt;
   endfunction

endpackage

// File: rtl/ets_csr.sv
// Configuration registers of the engine test sequencer.
module ets_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ets_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ets_pkg::REG_BITS-1:0]        csr_wdata,
   output ets_pkg::csr_type                    csr
);

   ets_pkg::csr_type csr_ff;

   // Load reset values, then take writes by index
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.countdown_delay_ms <= ets_pkg::RST_COUNTDOWN;
         csr_ff.purge_duration_ms  <= ets_pkg::RST_PURGE_DUR;
         csr_ff.purge_delay_ms     <= ets_pkg::RST_PURGE_DLY;
         csr_ff.ignition_delay_ms  <= ets_pkg::RST_IGNITION;
         csr_ff.ignition2_delay_ms <= ets_pkg::RST_IGNITION2;
         csr_ff.fire_duration_ms   <= ets_pkg::RST_FIRE_DUR;
         csr_ff.gradient_abort_ms  <= ets_pkg::RST_GRADIENT;
         csr_ff.auto_abort_on      <= ets_pkg::RST_AUTO;
      end else if (csr_we) begin
         case (csr_index)
            ets_pkg::REG_COUNTDOWN:  csr_ff.countdown_delay_ms <= csr_wdata;
            ets_pkg::REG_PURGE_DUR:  csr_ff.purge_duration_ms  <= csr_wdata;
            ets_pkg::REG_PURGE_DLY:  csr_ff.purge_delay_ms     <= csr_wdata;
            ets_pkg::REG_IGNITION:   csr_ff.ignition_delay_ms  <= csr_wdata;
            ets_pkg::REG_IGNITION2:  csr_ff.ignition2_delay_ms <= csr_wdata;
            ets_pkg::REG_FIRE_DUR:   csr_ff.fire_duration_ms   <= csr_wdata;
            ets_pkg::REG_GRADIENT:   csr_ff.gradient_abort_ms  <= csr_wdata;
            ets_pkg::REG_AUTO_ABORT: csr_ff.auto_abort_on      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr = csr_ff;

endmodule

// File: rtl/ets_core.sv
// Sequencer state, timers, pressure checks and next-state logic.
module ets_core #(
   parameter int TIMER_BITS = ets_pkg::TIMER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ets_pkg::item_type    item,
   input  ets_pkg::csr_type     csr,
   output ets_pkg::result_type  result
);

   localparam int CMP_BITS = (TIMER_BITS > ets_pkg::REG_BITS) ? TIMER_BITS
                                                              : ets_pkg::REG_BITS;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam int NC = ets_pkg::NUM_CHECKS;

   ets_pkg::seq_state_type            state_ff, state_in;
   logic                              safe_ff, safe_in;
   logic                              os_armed_ff, os_armed_in;
   logic [TIMER_BITS-1:0]             os_el_ff, os_el_in;
   logic [NC-1:0]                     chk_armed_ff, chk_armed_in;
   logic [TIMER_BITS-1:0]             chk_el_ff [NC];
   logic [TIMER_BITS-1:0]             chk_el_in [NC];
   logic [ets_pkg::NUM_STATES-1:0]    mask_ff, mask_in;

   logic [ets_pkg::REG_BITS-1:0]      dwell_delay;
   logic [TIMER_BITS-1:0]             os_inc;
   logic                              enter_en;
   ets_pkg::seq_state_type            enter_tgt;
   logic                              changed, trip, bad;
   logic [NC-1:0]                     cond;
   logic signed [ets_pkg::P_BITS:0]   p1, p2, p3, p4, p5;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      return (v == TIMER_MAX) ? v : TIMER_BITS'(v + 1'b1);
   endfunction

   // Select the dwell of the current state
   always_comb begin
      case (ets_pkg::dwell_reg_index(state_ff))
         ets_pkg::REG_COUNTDOWN: dwell_delay = csr.countdown_delay_ms;
         ets_pkg::REG_PURGE_DUR: dwell_delay = csr.purge_duration_ms;
         ets_pkg::REG_PURGE_DLY: dwell_delay = csr.purge_delay_ms;
         ets_pkg::REG_IGNITION:  dwell_delay = csr.ignition_delay_ms;
         ets_pkg::REG_IGNITION2: dwell_delay = csr.ignition2_delay_ms;
         ets_pkg::REG_FIRE_DUR:  dwell_delay = csr.fire_duration_ms;
         default:                dwell_delay = '0;
      endcase
   end

   // Widen pressures so margins cannot overflow
   always_comb begin
      p1 = {item.p_ox_tank[ets_pkg::P_BITS-1], item.p_ox_tank};
      p2 = {item.p_fuel_tank[ets_pkg::P_BITS-1], item.p_fuel_tank};
      p3 = {item.p_ox_inlet[ets_pkg::P_BITS-1], item.p_ox_inlet};
      p4 = {item.p_fuel_inlet[ets_pkg::P_BITS-1], item.p_fuel_inlet};
      p5 = {item.p_upper_line[ets_pkg::P_BITS-1], item.p_upper_line};
      cond[0] = p4 > (p2 - ets_pkg::MARGIN_15PSI);
      cond[1] = p3 > (p1 - ets_pkg::MARGIN_15PSI);
      cond[2] = p2 > (p5 + ets_pkg::MARGIN_10PSI);
   end

   assign os_inc = sat_inc(os_el_ff);

   // Next state for one request
   always_comb begin
      state_in     = state_ff;
      safe_in      = safe_ff;
      os_armed_in  = os_armed_ff;
      os_el_in     = os_el_ff;
      chk_armed_in = chk_armed_ff;
      chk_el_in    = chk_el_ff;
      enter_en     = 1'b0;
      enter_tgt    = ets_pkg::ST_FULLY_CLOSED;
      trip         = 1'b0;
      bad          = 1'b0;
      case (item.action)
         ets_pkg::ACT_TICK: begin
            for (int i = 0; i < NC; i++) begin
               if (chk_armed_ff[i]) chk_el_in[i] = sat_inc(chk_el_ff[i]);
            end
            if (os_armed_ff && ets_pkg::state_is_timed(state_ff)) begin
               os_el_in = os_inc;
               if (CMP_BITS'(os_inc) >= CMP_BITS'(dwell_delay)) begin
                  enter_en  = 1'b1;
                  enter_tgt = ets_pkg::dwell_next(state_ff);
               end
            end
         end
         ets_pkg::ACT_REQUEST: begin
            if (item.requested_state > ets_pkg::CODE_MAX) begin
               bad = 1'b1;
            end else begin
               enter_en  = 1'b1;
               enter_tgt = ets_pkg::code_to_state(item.requested_state);
            end
         end
         ets_pkg::ACT_ABORT: begin
            enter_en  = 1'b1;
            enter_tgt = ets_pkg::in_fire_zone(state_ff) ? ets_pkg::ST_SHUTDOWN1
                                                        : ets_pkg::ST_SHUTDOWN2;
         end
         ets_pkg::ACT_SAFE: begin
            safe_in = item.safe_flag;
         end
         ets_pkg::ACT_SAMPLE: begin
            if (!csr.auto_abort_on || !ets_pkg::in_fire_zone(state_ff)) begin
               chk_armed_in = '0;
               for (int i = 0; i < NC; i++) chk_el_in[i] = '0;
            end else begin
               for (int i = 0; i < NC; i++) begin
                  if (!cond[i]) begin
                     chk_armed_in[i] = 1'b0;
                     chk_el_in[i]    = '0;
                  end else if (!chk_armed_ff[i]) begin
                     chk_armed_in[i] = 1'b1;
                     chk_el_in[i]    = '0;
                  end else if (CMP_BITS'(chk_el_ff[i]) > CMP_BITS'(csr.gradient_abort_ms)) begin
                     trip = 1'b1;
                  end
               end
               if (trip) begin
                  enter_en  = 1'b1;
                  enter_tgt = ets_pkg::ST_SHUTDOWN1;
               end
            end
         end
         default: ;
      endcase
      // Entering a state restarts the one-shot
      if (enter_en) begin
         state_in    = enter_tgt;
         os_armed_in = ets_pkg::state_is_timed(enter_tgt);
         os_el_in    = '0;
      end
      changed = enter_en;
      mask_in = ets_pkg::allowed_mask(state_in, safe_in);
   end

   // Build the result of this request
   always_comb begin
      result.current_state = ets_pkg::state_to_code(state_in);
      result.allowed_mask  = mask_in;
      result.mask_changed  = mask_in != mask_ff;
      result.state_changed = changed;
      result.gradient_trip = trip;
      result.bad_request   = bad;
   end

   // Commit state when the request moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ets_pkg::ST_FULLY_CLOSED;
         safe_ff      <= 1'b0;
         os_armed_ff  <= 1'b0;
         os_el_ff     <= '0;
         chk_armed_ff <= '0;
         for (int i = 0; i < NC; i++) chk_el_ff[i] <= '0;
         mask_ff      <= '0;
      end else if (advance) begin
         state_ff     <= state_in;
         safe_ff      <= safe_in;
         os_armed_ff  <= os_armed_in;
         os_el_ff     <= os_el_in;
         chk_armed_ff <= chk_armed_in;
         chk_el_ff    <= chk_el_in;
         mask_ff      <= mask_in;
      end
   end

endmodule

// File: rtl/engine_test_sequencer_top.sv
// A request is held in the input register; its result is loaded into the output
// register once that is free or being drained. Throughput: one request per cycle
// while the output register is drained, through the combinational next-state logic.
// Reset (synchronous, active high) returns to Fully Closed with timers, checks
// and the last mask cleared and configuration registers at their defaults.
module engine_test_sequencer_top #(
   parameter int TIMER_BITS = ets_pkg::TIMER_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [2:0]                           req_action,
   input  logic [ets_pkg::CODE_BITS-1:0]        req_requested_state,
   input  logic                                 req_safe_flag,
   input  logic signed [ets_pkg::P_BITS-1:0]    req_p_ox_tank,
   input  logic signed [ets_pkg::P_BITS-1:0]    req_p_fuel_tank,
   input  logic signed [ets_pkg::P_BITS-1:0]    req_p_ox_inlet,
   input  logic signed [ets_pkg::P_BITS-1:0]    req_p_fuel_inlet,
   input  logic signed [ets_pkg::P_BITS-1:0]    req_p_upper_line,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ets_pkg::CODE_BITS-1:0]        rsp_current_state,
   output logic [ets_pkg::NUM_STATES-1:0]       rsp_allowed_mask,
   output logic                                 rsp_mask_changed,
   output logic                                 rsp_state_changed,
   output logic                                 rsp_gradient_trip,
   output logic                                 rsp_bad_request,
   input  logic                                 csr_we,
   input  logic [ets_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ets_pkg::REG_BITS-1:0]         csr_wdata
);

   ets_pkg::csr_type     csr;
   ets_pkg::item_type    s1_item_ff, s1_item_in;
   logic                 s1_valid_ff;
   ets_pkg::result_type  rsp_ff, core_result;
   logic                 rsp_valid_ff;
   logic                 advance;

   ets_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   ets_core #(.TIMER_BITS(TIMER_BITS)) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .csr     (csr),
      .result  (core_result)
   );

   // Advance when the output register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_item_in.action          = req_action;
      s1_item_in.requested_state = req_requested_state;
      s1_item_in.safe_flag       = req_safe_flag;
      s1_item_in.p_ox_tank       = req_p_ox_tank;
      s1_item_in.p_fuel_tank     = req_p_fuel_tank;
      s1_item_in.p_ox_inlet      = req_p_ox_inlet;
      s1_item_in.p_fuel_inlet    = req_p_fuel_inlet;
      s1_item_in.p_upper_line    = req_p_upper_line;
   end

   // Hold the request in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) s1_item_ff <= s1_item_in;
   end

   // Load the result register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= core_result;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_state = rsp_ff.current_state;
   assign rsp_allowed_mask  = rsp_ff.allowed_mask;
   assign rsp_mask_changed  = rsp_ff.mask_changed;
   assign rsp_state_changed = rsp_ff.state_changed;
   assign rsp_gradient_trip = rsp_ff.gradient_trip;
   assign rsp_bad_request   = rsp_ff.bad_request;

endmodule

// File: rtl/ets_checker.sv
// Port-level checker of the engine test sequencer and its bind.
`include "assert_macros.svh"

module ets_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [ets_pkg::CODE_BITS-1:0]        rsp_current_state,
   input logic [ets_pkg::NUM_STATES-1:0]       rsp_allowed_mask,
   input logic                                 rsp_state_changed,
   input logic                                 rsp_gradient_trip,
   input logic                                 rsp_bad_request
);

   // A stalled result stays valid and holds its state code and mask
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_current_state) && $stable(rsp_allowed_mask))

   // Reported state is a real state code
   `ASSERT_IMPLY(a_state_range, clock, reset, rsp_valid, rsp_current_state <= ets_pkg::CODE_MAX)

   // An ignored request never moves the sequence or trips a check
   `ASSERT_IMPLY(a_bad_quiet, clock, reset, rsp_valid && rsp_bad_request, !rsp_state_changed && !rsp_gradient_trip)

   // A trip always lands in shutdown phase 1 with a state change
   `ASSERT_IMPLY(a_trip_shutdown, clock, reset, rsp_valid && rsp_gradient_trip, rsp_state_changed && (rsp_current_state == ets_pkg::CODE_SHUTDOWN1))

endmodule

bind engine_test_sequencer_top ets_checker u_ets_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_current_state (rsp_current_state),
   .rsp_allowed_mask  (rsp_allowed_mask),
   .rsp_state_changed (rsp_state_changed),
   .rsp_gradient_trip (rsp_gradient_trip),
   .rsp_bad_request   (rsp_bad_request)
);
